[src/secded_pkg.sv]
// shared constants, types and the syndrome table of the secded(16,11) codec
package secded_pkg;

  localparam int unsigned DataW = 11;
  localparam int unsigned ChkW  = 4;
  localparam int unsigned WordW = 16;

  localparam logic [DataW-1:0] ChkMask0 = 11'h55B;
  localparam logic [DataW-1:0] ChkMask1 = 11'h66D;
  localparam logic [DataW-1:0] ChkMask2 = 11'h78E;
  localparam logic [DataW-1:0] ChkMask3 = 11'h7F0;

  localparam logic OpEncode = 1'b0;
  localparam logic OpDecode = 1'b1;

  typedef struct packed {
    logic [ChkW-1:0] chk;
    logic            data_par;
  } chk_t;

  // syndrome value (1..15) to the code word bit position it names
  function automatic logic [3:0] syn_to_pos(input logic [ChkW-1:0] syn);
    logic [3:0] pos;
    case (syn)
      4'd1:    pos = 4'd11;
      4'd2:    pos = 4'd12;
      4'd3:    pos = 4'd0;
      4'd4:    pos = 4'd13;
      4'd5:    pos = 4'd1;
      4'd6:    pos = 4'd2;
      4'd7:    pos = 4'd3;
      4'd8:    pos = 4'd14;
      4'd9:    pos = 4'd4;
      4'd10:   pos = 4'd5;
      4'd11:   pos = 4'd6;
      4'd12:   pos = 4'd7;
      4'd13:   pos = 4'd8;
      4'd14:   pos = 4'd9;
      4'd15:   pos = 4'd10;
      default: pos = 4'd15;
    endcase
    return pos;
  endfunction

endpackage

[src/secded_chkgen.sv]
// check bit generator: four hamming parities and the parity of the data bits
module secded_chkgen (
  input  logic [secded_pkg::DataW-1:0] data,
  output secded_pkg::chk_t             chk_o
);
  import secded_pkg::*;

  always_comb begin
    chk_o.chk[0]  = ^(data & ChkMask0);
    chk_o.chk[1]  = ^(data & ChkMask1);
    chk_o.chk[2]  = ^(data & ChkMask2);
    chk_o.chk[3]  = ^(data & ChkMask3);
    chk_o.data_par = ^data;
  end

endmodule

[src/secded_16_11_codec.sv]
// top level of the secded(16,11) extended hamming encoder and decoder
//
// usage:
//   an item is a transfer on the input side when start is high and busy is
//   low; in_opcode selects encode (data in in_word[10:0]) or decode (in_word
//   is a received code word). busy is low whenever reset is released, so a
//   new item can be given in every clock cycle.
//   every item gives exactly one result, shown on the out_ ports for one
//   cycle with out_valid high, once the item has passed the register stages.
//   encode returns the full code word; decode returns the corrected data in
//   bits 10:0 with the upper bits zero, plus corrected / uncorrectable flags.
//   throughput one item per cycle, through the three register stages:
//   check bit generation, syndrome and compare, correction.
//   the receiver takes each result in the cycle it is shown and cannot hold
//   it off, so the pipeline never stalls.
//   reset (synchronous, active low) empties the pipeline; items in flight
//   are dropped and no transfer is taken while reset is low.
module secded_16_11_codec (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [secded_pkg::WordW-1:0] in_word,
  output logic                         out_valid,
  output logic [secded_pkg::WordW-1:0] out_result_value,
  output logic                         out_corrected,
  output logic                         out_uncorrectable
);
  import secded_pkg::*;

  chk_t            chk_c;

  // stage 1
  logic            v1_r;
  logic            op1_r;
  logic [WordW-1:0] word1_r;
  chk_t            chk1_r;

  // stage 2
  logic            v2_r;
  logic            op2_r;
  logic [DataW-1:0] word2_r;
  logic [WordW-1:0] code2_r;
  logic [ChkW-1:0] syn2_r;
  logic            odd2_r;
  logic            mism2_r;
  logic [WordW-1:0] code2_nxt;

  // stage 3 (output)
  logic            v3_r;
  logic [WordW-1:0] value3_r;
  logic            corr3_r;
  logic            unc3_r;
  logic [WordW-1:0] value3_nxt;
  logic [3:0]      pos_c;
  logic [WordW-1:0] flip_c;

  assign busy = ~rst_n;

  secded_chkgen u_chkgen (
    .data  (in_word[DataW-1:0]),
    .chk_o (chk_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    op1_r   <= in_opcode;
    word1_r <= in_word;
    chk1_r  <= chk_c;
  end

  // overall parity is data parity folded with the check bits
  assign code2_nxt = {chk1_r.data_par ^ (^chk1_r.chk), chk1_r.chk, word1_r[DataW-1:0]};

  always_ff @(posedge clk) begin
    op2_r   <= op1_r;
    word2_r <= word1_r[DataW-1:0];
    code2_r <= code2_nxt;
    syn2_r  <= word1_r[DataW+ChkW-1:DataW] ^ chk1_r.chk;
    odd2_r  <= ^word1_r;
    mism2_r <= code2_nxt != word1_r;
  end

  assign pos_c  = syn_to_pos(syn2_r);
  assign flip_c = (odd2_r && syn2_r != '0) ? (WordW'(1) << pos_c) : '0;

  always_comb begin
    if (op2_r == OpEncode) begin
      value3_nxt = code2_r;
    end else if (mism2_r) begin
      value3_nxt = {{(WordW-DataW){1'b0}}, word2_r ^ flip_c[DataW-1:0]};
    end else begin
      value3_nxt = {{(WordW-DataW){1'b0}}, word2_r};
    end
  end

  always_ff @(posedge clk) begin
    value3_r <= value3_nxt;
    corr3_r  <= (op2_r == OpDecode) & mism2_r & odd2_r;
    unc3_r   <= (op2_r == OpDecode) & mism2_r & ~odd2_r;
  end

  assign out_valid         = v3_r;
  assign out_result_value  = value3_r;
  assign out_corrected     = corr3_r;
  assign out_uncorrectable = unc3_r;

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("transfer did not produce a result after three cycles");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_corrected && out_uncorrectable))
    else $error("corrected and uncorrectable both set");

  a_unc_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_uncorrectable || out_corrected)) |-> out_result_value[15:11] == 5'd0)
    else $error("decode result has upper bits set");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(v2_r)) |-> 1'b0)
    else $error("result without an item in flight");
`endif

endmodule

[tb/secded_check_pkg.sv]
// result predictor and scoreboard class for the secded(16,11) codec testbench
package secded_check_pkg;

  import secded_pkg::*;

  // code word bit named by each syndrome value 1..15
  parameter logic [3:0] SynBitPos [0:14] = '{
    4'd11, 4'd12, 4'd0, 4'd13, 4'd1, 4'd2, 4'd3, 4'd14,
    4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
  };

  typedef struct {
    logic [WordW-1:0] value;
    logic             corrected;
    logic             uncorrectable;
  } codec_result_t;

  // systematic code word for 11 data bits
  function automatic logic [WordW-1:0] secded_codeword(input logic [DataW-1:0] data);
    logic [WordW-1:0] cw;
    cw        = '0;
    cw[10:0]  = data;
    cw[11]    = ^(data & ChkMask0);
    cw[12]    = ^(data & ChkMask1);
    cw[13]    = ^(data & ChkMask2);
    cw[14]    = ^(data & ChkMask3);
    cw[15]    = ^cw[14:0];
    return cw;
  endfunction

  class secded_result_tracker;
    codec_result_t expected_results[$];
    int unsigned   fail_count;

    function new();
      fail_count = 0;
    endfunction

    function automatic codec_result_t decode_word(input logic op, input logic [WordW-1:0] w);
      codec_result_t    res;
      logic [WordW-1:0] recoded;
      logic [3:0]       syn;
      res.value         = '0;
      res.corrected     = 1'b0;
      res.uncorrectable = 1'b0;
      if (op == OpEncode) begin
        res.value = secded_codeword(w[DataW-1:0]);
      end else begin
        recoded       = secded_codeword(w[DataW-1:0]);
        res.value     = {5'b0, w[DataW-1:0]};
        if (recoded != w) begin
          if (^w) begin
            syn = w[14:11] ^ recoded[14:11];
            // zero syndrome: only the overall parity bit flipped
            if (syn != 4'd0)
              res.value = (w ^ (16'd1 << SynBitPos[syn - 4'd1])) & 16'h07FF;
            res.corrected = 1'b1;
          end else begin
            res.uncorrectable = 1'b1;
          end
        end
      end
      return res;
    endfunction

    function void note_item(input logic op, input logic [WordW-1:0] w);
      expected_results.push_back(decode_word(op, w));
    endfunction

    function void check_result(input logic [WordW-1:0] value, input logic corr,
                               input logic unc);
      codec_result_t want;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: value %h corrected %b uncorrectable %b",
                   value, corr, unc);
        return;
      end
      want = expected_results.pop_front();
      if (value !== want.value || corr !== want.corrected || unc !== want.uncorrectable) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"bad result: value exp %h got %h, corrected exp %b got %b, ",
                    "uncorrectable exp %b got %b"},
                   want.value, value, want.corrected, corr, want.uncorrectable, unc);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

[tb/secded_16_11_codec_tb.sv]
// testbench top for the secded(16,11) codec: directed and random encode/decode transfers
module secded_16_11_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import secded_pkg::*;
  import secded_check_pkg::*;

  localparam int unsigned RandomItems = 1130;
  localparam int unsigned QuietTail   = 150;
  localparam int unsigned CycleLimit  = 200000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_opcode;
  logic [WordW-1:0] in_word;
  logic             out_valid;
  logic [WordW-1:0] out_result_value;
  logic             out_corrected;
  logic             out_uncorrectable;

  secded_result_tracker tracker = new();
  int unsigned          cycle_count = 0;

  secded_16_11_codec dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_word           (in_word),
    .out_valid         (out_valid),
    .out_result_value  (out_result_value),
    .out_corrected     (out_corrected),
    .out_uncorrectable (out_uncorrectable)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("secded_16_11_codec: mismatch");
      $finish;
    end
  end

  // transfers on both sides, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        tracker.note_item(in_opcode, in_word);
      if (out_valid)
        tracker.check_result(out_result_value, out_corrected, out_uncorrectable);
    end
  end

  // start stays high across back-to-back transfers
  task automatic send_item(input logic op, input logic [WordW-1:0] w);
    @(negedge clk);
    start     <= 1'b1;
    in_opcode <= op;
    in_word   <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int unsigned n);
    @(negedge clk);
    start     <= 1'b0;
    in_opcode <= 1'($urandom_range(0, 1));
    in_word   <= WordW'($urandom_range(0, 16'hFFFF));
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_random_item();
    int unsigned      pick;
    int unsigned      b0;
    int unsigned      b1;
    logic [WordW-1:0] cw;
    pick = $urandom_range(0, 99);
    cw   = secded_codeword(DataW'($urandom_range(0, 2047)));
    b0   = $urandom_range(0, 15);
    b1   = (b0 + $urandom_range(1, 15)) % 16;
    if (pick < 35)
      send_item(OpEncode, WordW'($urandom_range(0, 16'hFFFF)));
    else if (pick < 55)
      send_item(OpDecode, cw);
    else if (pick < 80)
      send_item(OpDecode, cw ^ (16'd1 << b0));
    else if (pick < 92)
      send_item(OpDecode, cw ^ (16'd1 << b0) ^ (16'd1 << b1));
    else
      send_item(OpDecode, WordW'($urandom_range(0, 16'hFFFF)));
  endtask

  initial begin
    logic [WordW-1:0] clean;
    bit               gaps_on;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_opcode = OpEncode;
    in_word   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, clean words, single and double errors
    clean = secded_codeword(11'h7FF);
    send_item(OpEncode, 16'h0000);
    send_item(OpEncode, 16'hFFFF);
    send_item(OpEncode, 16'hF800);
    send_item(OpEncode, 16'h0555);
    send_item(OpEncode, 16'h02AA);
    send_item(OpDecode, 16'h0000);
    send_item(OpDecode, 16'hFFFF);
    send_item(OpDecode, clean);
    send_item(OpDecode, clean ^ 16'h8000);
    send_item(OpDecode, clean ^ 16'h0800);
    send_item(OpDecode, clean ^ 16'h1000);
    send_item(OpDecode, clean ^ 16'h2000);
    send_item(OpDecode, clean ^ 16'h4000);
    send_item(OpDecode, clean ^ 16'h0001);
    send_item(OpDecode, clean ^ 16'h0400);
    send_item(OpDecode, clean ^ 16'h0003);
    send_item(OpDecode, clean ^ 16'h8001);
    send_item(OpDecode, clean ^ 16'h4010);
    send_item(OpDecode, clean ^ 16'h0007);
    send_item(OpDecode, secded_codeword(11'h2A5) ^ 16'h0020);

    gaps_on = 1'b1;
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0)
        gaps_on = ($urandom_range(0, 3) != 0);
      if (i == RandomItems / 2) begin
        idle_gap(1);
        while (tracker.pending() != 0) @(posedge clk);
      end
      if (gaps_on && i < RandomItems - QuietTail && $urandom_range(0, 3) == 0)
        idle_gap($urandom_range(1, 11));
      send_random_item();
    end
    @(negedge clk);
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending() == 0)
      $display("secded_16_11_codec: match");
    else
      $display("secded_16_11_codec: mismatch");
    $finish;
  end

endmodule
